### rtl/core/edt3d_pkg.sv
// shared constants for the 3d euclidean distance transform
package edt3d_pkg;
    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_MARK  = 2'd1;
    localparam logic [1:0] KIND_XFORM = 2'd2;
    localparam logic [1:0] KIND_QUERY = 2'd3;
    localparam logic [1:0] REG_SIZE_X = 2'd0;
    localparam logic [1:0] REG_SIZE_Y = 2'd1;
    localparam logic [1:0] REG_SIZE_Z = 2'd2;
    localparam logic [1:0] REG_VOXEL  = 2'd3;
    localparam logic [15:0] SENTINEL   = 16'hFFFF;
    localparam logic [21:0] METRIC_MAX = 22'h3FFFFF;
endpackage

### rtl/core/edt3d_isqrt.sv
// multi-cycle integer square root, one result bit per cycle
module edt3d_isqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [31:0] value,
    output logic        done,
    output logic [15:0] root
);
    logic [31:0] rem_reg, rem_next;
    logic [15:0] root_reg, root_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [33:0] trial;
    logic [33:0] rem_sh;

    always_comb
    begin
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        // restoring method: bring down two bits per step
        rem_sh = {rem_reg[31:0], 2'b00};
        trial  = {16'd0, root_reg, 2'b01};
        if (go)
        begin
            rem_next  = value;
            root_next = '0;
            cnt_next  = '0;
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            rem_sh = {2'b00, rem_reg};
            trial  = {16'd0, root_reg, 2'b01} << {cnt_reg ^ 5'd15, 1'b0};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh[31:0] - trial[31:0];
                root_next = {root_reg[14:0], 1'b1};
            end
            else
            begin
                root_next = {root_reg[14:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd15)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

### rtl/core/euclidean_distance_transform_3d_top.sv
// top level of the 3d euclidean distance transform block
// a volume of 16-bit squared cell distances sits in one synchronous memory
// (DIM^3 entries, one read or one write per cycle). start is taken when busy
// is low; every item produces exactly one result, shown for one cycle with
// result_valid high, and the receiver cannot stall it. a mark or a rejected
// coordinate goes straight to the done state; a query does a memory read, a
// 16-step square root and a scale multiply, or skips the root and multiply
// when the voxel holds the sentinel; a clear sweeps all nx*ny*nz voxels; a
// transform walks every line of the three axes, loading each sample, building
// the hull (steps and pops), advancing the envelope and writing each sample
// back, its pace set by the single memory port and the line scratch stores.
// no clearing pass follows reset: the volume is undefined until a clear item
// runs.
module euclidean_distance_transform_3d_top #(
    parameter int DIM = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  kind,
    input  logic [5:0]  vox_x,
    input  logic [5:0]  vox_y,
    input  logic [5:0]  vox_z,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        result_valid,
    output logic        status,
    output logic [15:0] squared_distance,
    output logic [21:0] metric_distance,
    output logic        no_surface
);
    import edt3d_pkg::*;

    localparam int AW  = $clog2(DIM);
    localparam int VAW = 3 * AW;
    localparam int VD  = DIM * DIM * DIM;
    localparam int CW  = AW + 1;

    // states
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_CLEAR  = 5'd1;
    localparam logic [4:0] S_QRD    = 5'd2;
    localparam logic [4:0] S_QSQ    = 5'd3;
    localparam logic [4:0] S_QWAIT  = 5'd4;
    localparam logic [4:0] S_QMUL   = 5'd5;
    localparam logic [4:0] S_QOUT   = 5'd6;
    localparam logic [4:0] S_LRD    = 5'd7;
    localparam logic [4:0] S_LCAP   = 5'd8;
    localparam logic [4:0] S_HINIT  = 5'd9;
    localparam logic [4:0] S_HRD    = 5'd10;
    localparam logic [4:0] S_HCMP   = 5'd11;
    localparam logic [4:0] S_HMUL   = 5'd12;
    localparam logic [4:0] S_HDEC   = 5'd13;
    localparam logic [4:0] S_ERD    = 5'd14;
    localparam logic [4:0] S_EMUL   = 5'd15;
    localparam logic [4:0] S_EDEC   = 5'd16;
    localparam logic [4:0] S_EVAL   = 5'd17;
    localparam logic [4:0] S_EWR    = 5'd18;
    localparam logic [4:0] S_NEXTL  = 5'd19;
    localparam logic [4:0] S_DONE   = 5'd20;

    // configuration
    logic [5:0]  size_x_reg, size_y_reg, size_z_reg;
    logic [15:0] voxel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= 6'd32;
            size_y_reg <= 6'd32;
            size_z_reg <= 6'd32;
            voxel_reg  <= 16'd1024;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SIZE_X: size_x_reg <= cfg_data[5:0];
                REG_SIZE_Y: size_y_reg <= cfg_data[5:0];
                REG_SIZE_Z: size_z_reg <= cfg_data[5:0];
                REG_VOXEL:  voxel_reg  <= cfg_data;
                default:    voxel_reg  <= voxel_reg;
            endcase
        end
    end

    // sizes clamped into 1..DIM
    function automatic logic [CW-1:0] in_use(input logic [5:0] s);
        logic [CW-1:0] r;
        if (s == 6'd0)
            r = CW'(1);
        else if (32'(s) > DIM)
            r = CW'(DIM);
        else
            r = CW'(s);
        return r;
    endfunction

    logic [CW-1:0] nx, ny, nz;
    assign nx = in_use(size_x_reg);
    assign ny = in_use(size_y_reg);
    assign nz = in_use(size_z_reg);

    // volume memory
    logic [15:0] vol_mem [VD];
    logic [VAW-1:0] vaddr;
    logic        vwe;
    logic [15:0] vwdata;
    logic [15:0] vrdata_reg;

    always_ff @(posedge clk)
    begin
        if (vwe)
            vol_mem[vaddr] <= vwdata;
        vrdata_reg <= vol_mem[vaddr];
    end

    // line scratch: samples, apex and cut stores, all single-port arrays
    logic [15:0] samp_mem [DIM];
    logic [AW-1:0] apex_mem [DIM];
    logic signed [17:0] cnum_mem [DIM+1];
    logic [6:0]  cden_mem [DIM+1];

    logic [1:0]  axis_reg;
    logic [AW-1:0] la_reg, lb_reg;
    logic [CW-1:0] li_reg;
    logic [CW-1:0] q_reg;
    logic [CW-1:0] k_reg, top_reg;
    logic [AW-1:0] p_reg;
    logic [15:0] sp_reg, sq_reg;
    logic signed [17:0] num_reg, cn_reg;
    logic [6:0]  den_reg, cd_reg;
    logic signed [26:0] lhs_reg, rhs_reg;
    logic [CW-1:0] lane_n;

    logic [4:0]  st_reg;
    logic [AW-1:0] cx_reg, cy_reg, cz_reg;

    // result outputs
    logic        rv_reg;
    logic        stat_reg, nos_reg;
    logic [15:0] sd_reg;
    logic [21:0] md_reg;
    logic [37:0] prod_reg;

    logic        sq_go;
    logic        sq_done;
    logic [15:0] sq_root;

    // the root starts in the cycle the read data arrives
    edt3d_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (sq_go),
        .value ({vrdata_reg, 16'd0}),
        .done  (sq_done),
        .root  (sq_root)
    );

    assign lane_n = (axis_reg == 2'd0) ? nx : ((axis_reg == 2'd1) ? ny : nz);

    // voxel address along the current line at offset i
    function automatic logic [VAW-1:0] line_addr(input logic [1:0] ax,
                                                  input logic [AW-1:0] a,
                                                  input logic [AW-1:0] b,
                                                  input logic [AW-1:0] i);
        logic [VAW-1:0] r;
        case (ax)
            2'd0:    r = {b, a, i};
            2'd1:    r = {b, i, a};
            default: r = {i, b, a};
        endcase
        return r;
    endfunction

    logic [AW-1:0] qi;
    assign qi = q_reg[AW-1:0];

    logic range_bad;
    assign range_bad = ({1'b0, vox_x} >= 7'(nx)) || ({1'b0, vox_y} >= 7'(ny))
                       || ({1'b0, vox_z} >= 7'(nz));

    // memory port steering
    always_comb
    begin
        vwe    = 1'b0;
        vwdata = SENTINEL;
        vaddr  = {cz_reg, cy_reg, cx_reg};
        case (st_reg)
            S_IDLE:
            begin
                vaddr = {vox_z[AW-1:0], vox_y[AW-1:0], vox_x[AW-1:0]};
                vwdata = 16'd0;
                vwe = start && (kind == KIND_MARK) && !range_bad;
            end
            S_CLEAR:
            begin
                vwe = 1'b1;
            end
            S_LRD, S_LCAP:
            begin
                vaddr = line_addr(axis_reg, la_reg, lb_reg, li_reg[AW-1:0]);
            end
            S_EWR:
            begin
                vaddr = line_addr(axis_reg, la_reg, lb_reg, qi);
                vwe = 1'b1;
                vwdata = sd_reg;
            end
            default:
            begin
                vwe = 1'b0;
            end
        endcase
    end

    // envelope arithmetic
    logic signed [17:0] fq, fp, num_w;
    logic [7:0] den_w;
    logic [31:0] sum_w;
    logic signed [CW:0] dq;
    always_comb
    begin
        fq    = 18'(sq_reg) + 18'(q_reg * q_reg);
        fp    = 18'(sp_reg) + 18'(p_reg * p_reg);
        num_w = fq - fp;
        den_w = 8'({q_reg, 1'b0} - {1'b0, p_reg, 1'b0});
        dq    = $signed({1'b0, q_reg}) - $signed({2'b00, p_reg});
        sum_w = 32'(dq * dq) + 32'(sp_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            rv_reg <= 1'b0;
        end
        else
        begin
            rv_reg <= 1'b0;
            case (st_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cx_reg <= vox_x[AW-1:0];
                        cy_reg <= vox_y[AW-1:0];
                        cz_reg <= vox_z[AW-1:0];
                        stat_reg <= 1'b0;
                        sd_reg <= '0;
                        md_reg <= '0;
                        nos_reg <= 1'b0;
                        case (kind)
                            KIND_CLEAR:
                            begin
                                cx_reg <= '0;
                                cy_reg <= '0;
                                cz_reg <= '0;
                                st_reg <= S_CLEAR;
                            end
                            KIND_XFORM:
                            begin
                                axis_reg <= 2'd0;
                                la_reg <= '0;
                                lb_reg <= '0;
                                li_reg <= '0;
                                st_reg <= S_LRD;
                            end
                            default:
                            begin
                                if (range_bad)
                                begin
                                    stat_reg <= 1'b1;
                                    st_reg <= S_DONE;
                                end
                                else if (kind == KIND_MARK)
                                    st_reg <= S_DONE;
                                else
                                    st_reg <= S_QRD;
                            end
                        endcase
                    end
                end
                S_CLEAR:
                begin
                    if (CW'(cx_reg) + CW'(1) < nx)
                        cx_reg <= cx_reg + AW'(1);
                    else
                    begin
                        cx_reg <= '0;
                        if (CW'(cy_reg) + CW'(1) < ny)
                            cy_reg <= cy_reg + AW'(1);
                        else
                        begin
                            cy_reg <= '0;
                            if (CW'(cz_reg) + CW'(1) < nz)
                                cz_reg <= cz_reg + AW'(1);
                            else
                                st_reg <= S_DONE;
                        end
                    end
                end
                S_QRD:   st_reg <= S_QSQ;
                S_QSQ:
                begin
                    sd_reg <= vrdata_reg;
                    if (vrdata_reg == SENTINEL)
                    begin
                        md_reg <= METRIC_MAX;
                        nos_reg <= 1'b1;
                        st_reg <= S_DONE;
                    end
                    else
                        st_reg <= S_QWAIT;
                end
                S_QWAIT:
                begin
                    if (sq_done)
                    begin
                        prod_reg <= 38'(sq_root * voxel_reg);
                        st_reg <= S_QMUL;
                    end
                end
                S_QMUL:
                begin
                    if (prod_reg[37:30] != 8'd0)
                        md_reg <= METRIC_MAX;
                    else
                        md_reg <= prod_reg[29:8];
                    st_reg <= S_DONE;
                end
                // line load: read each sample into the scratch store
                S_LRD:
                begin
                    st_reg <= S_LCAP;
                end
                S_LCAP:
                begin
                    samp_mem[li_reg[AW-1:0]] <= vrdata_reg;
                    if (li_reg + CW'(1) < lane_n)
                    begin
                        li_reg <= li_reg + CW'(1);
                        st_reg <= S_LRD;
                    end
                    else
                        st_reg <= S_HINIT;
                end
                S_HINIT:
                begin
                    apex_mem[0] <= '0;
                    cnum_mem[0] <= '0;
                    cden_mem[0] <= 7'd1;
                    k_reg <= '0;
                    q_reg <= CW'(1);
                    if (lane_n == CW'(1))
                    begin
                        top_reg <= '0;
                        k_reg <= '0;
                        q_reg <= '0;
                        st_reg <= S_ERD;
                    end
                    else
                        st_reg <= S_HRD;
                end
                // hull build: fetch apex of k and the sample of q
                S_HRD:
                begin
                    p_reg <= apex_mem[k_reg[AW-1:0]];
                    cn_reg <= cnum_mem[k_reg];
                    cd_reg <= cden_mem[k_reg];
                    sq_reg <= samp_mem[qi];
                    st_reg <= S_HCMP;
                end
                S_HCMP:
                begin
                    sp_reg <= samp_mem[p_reg];
                    st_reg <= S_HMUL;
                end
                S_HMUL:
                begin
                    num_reg <= num_w;
                    den_reg <= den_w[6:0];
                    lhs_reg <= 27'(num_w * $signed({1'b0, cd_reg}));
                    rhs_reg <= 27'(cn_reg * $signed({1'b0, den_w}));
                    st_reg <= S_HDEC;
                end
                S_HDEC:
                begin
                    if (k_reg != '0 && lhs_reg <= rhs_reg)
                    begin
                        k_reg <= k_reg - CW'(1);
                        st_reg <= S_HRD;
                    end
                    else
                    begin
                        k_reg <= k_reg + CW'(1);
                        apex_mem[AW'(k_reg + CW'(1))] <= qi;
                        cnum_mem[k_reg + CW'(1)] <= num_reg;
                        cden_mem[k_reg + CW'(1)] <= den_reg;
                        if (q_reg + CW'(1) < lane_n)
                        begin
                            q_reg <= q_reg + CW'(1);
                            st_reg <= S_HRD;
                        end
                        else
                        begin
                            top_reg <= k_reg + CW'(1);
                            k_reg <= '0;
                            q_reg <= '0;
                            st_reg <= S_ERD;
                        end
                    end
                end
                // envelope evaluation: advance k while the next cut lies left of q
                S_ERD:
                begin
                    cn_reg <= cnum_mem[k_reg + CW'(1)];
                    cd_reg <= cden_mem[k_reg + CW'(1)];
                    p_reg <= apex_mem[k_reg[AW-1:0]];
                    st_reg <= S_EMUL;
                end
                S_EMUL:
                begin
                    rhs_reg <= 27'($signed({1'b0, q_reg}) * $signed({1'b0, cd_reg}));
                    lhs_reg <= 27'(cn_reg);
                    sp_reg <= samp_mem[p_reg];
                    st_reg <= S_EDEC;
                end
                S_EDEC:
                begin
                    if (k_reg < top_reg && lhs_reg < rhs_reg)
                    begin
                        k_reg <= k_reg + CW'(1);
                        st_reg <= S_ERD;
                    end
                    else
                        st_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    sd_reg <= (sum_w > 32'(SENTINEL)) ? SENTINEL : sum_w[15:0];
                    st_reg <= S_EWR;
                end
                S_EWR:
                begin
                    sd_reg <= '0;
                    if (q_reg + CW'(1) < lane_n)
                    begin
                        q_reg <= q_reg + CW'(1);
                        st_reg <= S_ERD;
                    end
                    else
                        st_reg <= S_NEXTL;
                end
                // step to the next line, then the next axis
                S_NEXTL:
                begin
                    li_reg <= '0;
                    st_reg <= S_LRD;
                    if (CW'(la_reg) + CW'(1) < ((axis_reg == 2'd0) ? ny : nx))
                        la_reg <= la_reg + AW'(1);
                    else
                    begin
                        la_reg <= '0;
                        if (CW'(lb_reg) + CW'(1) < ((axis_reg == 2'd2) ? ny : nz))
                            lb_reg <= lb_reg + AW'(1);
                        else
                        begin
                            lb_reg <= '0;
                            if (axis_reg == 2'd2)
                                st_reg <= S_DONE;
                            else
                                axis_reg <= axis_reg + 2'd1;
                        end
                    end
                end
                S_DONE:
                begin
                    rv_reg <= 1'b1;
                    st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    assign sq_go = (st_reg == S_QSQ) && (vrdata_reg != SENTINEL);

    assign busy             = (st_reg != S_IDLE);
    assign result_valid     = rv_reg;
    assign status           = stat_reg;
    assign squared_distance = rv_reg ? sd_reg : 16'd0;
    assign metric_distance  = md_reg;
    assign no_surface       = nos_reg;
endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for the 3d euclidean distance transform block

module testbench;
    import edt3d_pkg::*;

    localparam int DIM = 32;
    // worst silent stretch is a 16^3 transform with every pop
    localparam int WATCHDOG_LIMIT = 1000000;

    typedef struct packed {
        logic        status;
        logic [15:0] squared_distance;
        logic [21:0] metric_distance;
        logic        no_surface;
    } query_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  kind;
    logic [5:0]  vox_x;
    logic [5:0]  vox_y;
    logic [5:0]  vox_z;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        result_valid;
    logic        status;
    logic [15:0] squared_distance;
    logic [21:0] metric_distance;
    logic        no_surface;

    euclidean_distance_transform_3d_top #(.DIM(DIM)) uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .kind             (kind),
        .vox_x            (vox_x),
        .vox_y            (vox_y),
        .vox_z            (vox_z),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .result_valid     (result_valid),
        .status           (status),
        .squared_distance (squared_distance),
        .metric_distance  (metric_distance),
        .no_surface       (no_surface)
    );

    // shadow copy of the block state
    logic [15:0] shadow_volume [DIM*DIM*DIM];
    logic [5:0]  shadow_size_x, shadow_size_y, shadow_size_z;
    logic [15:0] shadow_voxel_size;

    // line scratch for the lower-envelope pass
    int     line_in  [DIM];
    int     line_out [DIM];
    int     apex     [DIM];
    longint cut_num  [DIM+1];
    longint cut_den  [DIM+1];

    query_result_t pending_results[$];
    int  mismatch_count;
    int  idle_cycles;
    bit  idle_allowed;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int size_in_use(logic [5:0] s);
        if (s < 1) return 1;
        if (s > DIM) return DIM;
        return s;
    endfunction

    function automatic int voxel_addr(int x, int y, int z);
        return x + DIM * (y + DIM * z);
    endfunction

    function automatic longint root_floor(longint v);
        longint r;
        longint b;
        r = 0;
        b = 64'd1 << 30;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // exact lower envelope of parabolas over line_in[0..n-1] into line_out
    task automatic lower_envelope(int n);
        int k;
        int top;
        int q;
        int p;
        int dq;
        longint fq;
        longint num;
        longint den;
        longint total;
        k = 0;
        apex[0] = 0;
        cut_num[0] = 0;
        cut_den[0] = 1;
        for (q = 1; q < n; q++)
        begin
            fq = line_in[q] + q * q;
            forever
            begin
                p = apex[k];
                num = fq - (line_in[p] + p * p);
                den = 2 * (q - p);
                if (k > 0 && num * cut_den[k] <= cut_num[k] * den)
                    k--;
                else
                    break;
            end
            k++;
            apex[k] = q;
            cut_num[k] = num;
            cut_den[k] = den;
        end
        top = k;
        k = 0;
        for (q = 0; q < n; q++)
        begin
            while (k < top && cut_num[k+1] < q * cut_den[k+1]) k++;
            dq = q - apex[k];
            total = dq * dq + line_in[apex[k]];
            line_out[q] = (total > 65535) ? 65535 : int'(total);
        end
    endtask

    task automatic transform_line(int base, int stride, int n);
        int i;
        for (i = 0; i < n; i++) line_in[i] = shadow_volume[base + i * stride];
        lower_envelope(n);
        for (i = 0; i < n; i++) shadow_volume[base + i * stride] = line_out[i][15:0];
    endtask

    // advance the shadow state by one item and return the result it causes
    task automatic predict_item(input logic [1:0] k, input logic [5:0] x, input logic [5:0] y,
                                input logic [5:0] z, output query_result_t r);
        int nx;
        int ny;
        int nz;
        int a;
        int b;
        int c;
        longint d2;
        longint m;
        nx = size_in_use(shadow_size_x);
        ny = size_in_use(shadow_size_y);
        nz = size_in_use(shadow_size_z);
        r = '0;
        if (k == KIND_CLEAR)
        begin
            for (c = 0; c < nz; c++)
                for (b = 0; b < ny; b++)
                    for (a = 0; a < nx; a++) shadow_volume[voxel_addr(a, b, c)] = SENTINEL;
        end
        else if (k == KIND_XFORM)
        begin
            for (b = 0; b < nz; b++)
                for (a = 0; a < ny; a++) transform_line(voxel_addr(0, a, b), 1, nx);
            for (b = 0; b < nz; b++)
                for (a = 0; a < nx; a++) transform_line(voxel_addr(a, 0, b), DIM, ny);
            for (b = 0; b < ny; b++)
                for (a = 0; a < nx; a++) transform_line(voxel_addr(a, b, 0), DIM * DIM, nz);
        end
        else if (x >= nx || y >= ny || z >= nz)
            r.status = 1'b1;
        else if (k == KIND_MARK)
            shadow_volume[voxel_addr(x, y, z)] = 16'd0;
        else
        begin
            d2 = shadow_volume[voxel_addr(x, y, z)];
            r.squared_distance = d2[15:0];
            if (d2 >= SENTINEL)
            begin
                r.metric_distance = METRIC_MAX;
                r.no_surface = 1'b1;
            end
            else
            begin
                m = (root_floor(d2 << 16) * shadow_voxel_size) >> 8;
                r.metric_distance = (m > METRIC_MAX) ? METRIC_MAX : m[21:0];
            end
        end
    endtask

    function automatic int random_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (!idle_allowed || pick < 65) return 0;
        if (pick < 94) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // drive one item, wait for it to be taken, record what it should produce
    task automatic send_item(logic [1:0] k, logic [5:0] x, logic [5:0] y, logic [5:0] z);
        query_result_t r;
        bit taken;
        int gap;
        @(negedge clk);
        start = 1'b1;
        kind  = k;
        vox_x = x;
        vox_y = y;
        vox_z = z;
        do
        begin
            @(posedge clk);
            taken = !busy;
        end
        while (!taken);
        predict_item(k, x, y, z, r);
        pending_results.push_back(r);
        gap = random_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // hold off the sender until every result is back, then let the block settle
    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        case (idx)
            REG_SIZE_X: shadow_size_x = value[5:0];
            REG_SIZE_Y: shadow_size_y = value[5:0];
            REG_SIZE_Z: shadow_size_z = value[5:0];
            default:    shadow_voxel_size = value;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic configure(logic [15:0] sx, logic [15:0] sy, logic [15:0] sz,
                             logic [15:0] vs);
        drain();
        write_reg(REG_SIZE_X, sx);
        write_reg(REG_SIZE_Y, sy);
        write_reg(REG_SIZE_Z, sz);
        write_reg(REG_VOXEL, vs);
    endtask

    // full-size clear first so no voxel is ever read before it was written
    task automatic test_clear_and_bounds();
        send_item(KIND_CLEAR, 6'd0, 6'd0, 6'd0);
        send_item(KIND_QUERY, 6'd0, 6'd0, 6'd0);
        send_item(KIND_QUERY, 6'd31, 6'd31, 6'd31);
        send_item(KIND_MARK, 6'd31, 6'd31, 6'd31);
        send_item(KIND_QUERY, 6'd31, 6'd31, 6'd31);
        // coordinates past the sizes in use on each axis
        send_item(KIND_MARK, 6'd32, 6'd0, 6'd0);
        send_item(KIND_QUERY, 6'd0, 6'd32, 6'd0);
        send_item(KIND_QUERY, 6'd0, 6'd0, 6'd63);
        send_item(KIND_MARK, 6'd63, 6'd63, 6'd63);
    endtask

    // one long axis at a time, with size 0 and oversize values clamped
    task automatic test_axis_extremes();
        configure(16'd32, 16'd0, 16'd1, 16'd1024);
        send_item(KIND_CLEAR, 6'd0, 6'd0, 6'd0);
        send_item(KIND_XFORM, 6'd0, 6'd0, 6'd0);
        send_item(KIND_QUERY, 6'd5, 6'd0, 6'd0);
        send_item(KIND_MARK, 6'd0, 6'd0, 6'd0);
        send_item(KIND_XFORM, 6'd0, 6'd0, 6'd0);
        send_item(KIND_QUERY, 6'd31, 6'd0, 6'd0);
        configure(16'd1, 16'd63, 16'd0, 16'd65535);
        send_item(KIND_CLEAR, 6'd0, 6'd0, 6'd0);
        send_item(KIND_MARK, 6'd0, 6'd31, 6'd0);
        send_item(KIND_XFORM, 6'd0, 6'd0, 6'd0);
        send_item(KIND_QUERY, 6'd0, 6'd0, 6'd0);
        send_item(KIND_QUERY, 6'd0, 6'd0, 6'd1);
        configure(16'd0, 16'd1, 16'hFFE0, 16'd0);
        send_item(KIND_CLEAR, 6'd0, 6'd0, 6'd0);
        send_item(KIND_MARK, 6'd0, 6'd0, 6'd16);
        send_item(KIND_XFORM, 6'd0, 6'd0, 6'd0);
        send_item(KIND_QUERY, 6'd0, 6'd0, 6'd31);
    endtask

    // phases of well-formed clear/mark/transform/query runs with some noise
    task automatic test_random_volumes(int phases);
        int ph;
        int i;
        int nx;
        int ny;
        int nz;
        int marks;
        int queries;
        logic [15:0] vs;
        logic [1:0] k;
        for (ph = 0; ph < phases; ph++)
        begin
            idle_allowed = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0)
            begin
                nx = $urandom_range(1, 16);
                ny = $urandom_range(1, 16);
                nz = $urandom_range(1, 16);
            end
            else
            begin
                nx = $urandom_range(1, 8);
                ny = $urandom_range(1, 8);
                nz = $urandom_range(1, 8);
            end
            case ($urandom_range(0, 3))
                0:       vs = 16'($urandom_range(1, 65535));
                1:       vs = 16'hFFFF;
                default: vs = 16'($urandom_range(1, 4096));
            endcase
            // upper cfg_data bits are don't-care for the sizes
            configure({10'($urandom_range(0, 1023)), 6'(nx)},
                      {10'($urandom_range(0, 1023)), 6'(ny)},
                      {10'($urandom_range(0, 1023)), 6'(nz)}, vs);
            send_item(KIND_CLEAR, 6'($urandom), 6'($urandom), 6'($urandom));
            marks = $urandom_range(0, 4);
            for (i = 0; i < marks; i++)
                send_item(KIND_MARK, 6'($urandom_range(0, nx - 1)),
                          6'($urandom_range(0, ny - 1)), 6'($urandom_range(0, nz - 1)));
            send_item(KIND_XFORM, 6'($urandom), 6'($urandom), 6'($urandom));
            queries = $urandom_range(12, 28);
            for (i = 0; i < queries; i++)
            begin
                if ($urandom_range(0, 9) < 8)
                    send_item(KIND_QUERY, 6'($urandom_range(0, nx - 1)),
                              6'($urandom_range(0, ny - 1)), 6'($urandom_range(0, nz - 1)));
                else
                begin
                    // noise: any kind, any coordinate; transforms kept rare
                    k = 2'($urandom_range(0, 3));
                    if (k == KIND_XFORM && $urandom_range(0, 3) != 0) k = KIND_QUERY;
                    send_item(k, 6'($urandom), 6'($urandom), 6'($urandom));
                end
            end
        end
    endtask

    // result checker and watchdog
    always @(posedge clk)
    begin
        query_result_t got;
        query_result_t want;
        if (rst_n)
        begin
            if ((start && !busy) || result_valid)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
            if (result_valid)
            begin
                got = {status, squared_distance, metric_distance, no_surface};
                if (pending_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result %h at %0t", got, $realtime);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: status %b/%b d2 %0d/%0d metric %0d/%0d ns %b/%b",
                                     got.status, want.status, got.squared_distance,
                                     want.squared_distance, got.metric_distance,
                                     want.metric_distance, got.no_surface, want.no_surface);
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        kind = KIND_CLEAR;
        vox_x = '0;
        vox_y = '0;
        vox_z = '0;
        cfg_we = 1'b0;
        cfg_index = REG_SIZE_X;
        cfg_data = '0;
        mismatch_count = 0;
        idle_cycles = 0;
        idle_allowed = 1'b1;
        shadow_size_x = 6'd32;
        shadow_size_y = 6'd32;
        shadow_size_z = 6'd32;
        shadow_voxel_size = 16'd1024;
        foreach (shadow_volume[i]) shadow_volume[i] = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        test_clear_and_bounds();
        test_axis_extremes();
        test_random_volumes(72);

        drain();
        repeat (40) @(negedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
